@@ src/inverse_park_svpwm_duty_defines.svh @@
// Assertion macros for the inverse Park / SVPWM duty block.
// Included by modules that carry assertions; empty bodies under SYNTHESIS.
`ifndef INVERSE_PARK_SVPWM_DUTY_DEFINES_SVH
`define INVERSE_PARK_SVPWM_DUTY_DEFINES_SVH
`ifndef SYNTHESIS
`define IPSD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ipsd assertion failed");
`define IPSD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipsd assertion failed");
`else
`define IPSD_ASSERT(lbl, clk, rst, prop)
`define IPSD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ src/ipsd_pkg.sv @@
// Shared types, constants and tables for the inverse Park / SVPWM duty block.
// No dependencies.
package ipsd_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int XW = 32;   // CORDIC x/y width
  localparam int ZW = 34;   // CORDIC angle width, turn * 2^32
  localparam int QB = 17;   // quotient bits of the time divider
  localparam int DW = 37;   // dividend width of the time divider

  localparam logic signed [XW-1:0] KINV_Q30       = 32'sd652032874;
  localparam logic signed [XW-1:0] HALF_SQRT3_Q30 = 32'sd929887697;
  localparam logic [16:0]          SQRT3_Q16      = 17'd113512;
  localparam logic signed [XW-1:0] MAG_MIN_Q20    = 32'sd1049;
  localparam logic signed [ZW-1:0] TURN_HALF      = 34'sd2147483648;
  localparam logic signed [ZW-1:0] TURN_QUARTER   = 34'sd1073741824;

  typedef enum logic {
    REG_POLE_PAIRS = 1'b0,
    REG_PWM_PERIOD = 1'b1
  } ipsd_reg_t;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } ipsd_sector_t;

  // sideband riding along the third CORDIC
  typedef struct packed {
    logic [15:0] vbus;
    logic [31:0] mag;
    logic [2:0]  sector;
  } ipsd_side_t;

  function automatic logic signed [ZW-1:0] atan_turn(input int unsigned idx);
    logic signed [ZW-1:0] r;
    unique case (idx)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // start of each sector in turn * 2^32, rounded up
  function automatic logic [31:0] sect_base(input logic [2:0] s);
    logic [31:0] r;
    unique case (s)
      SEC_0:   r = 32'd0;
      SEC_1:   r = 32'd715827883;
      SEC_2:   r = 32'd1431655766;
      SEC_3:   r = 32'd2147483648;
      SEC_4:   r = 32'd2863311531;
      SEC_5:   r = 32'd3579139414;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/ipsd_cordic.sv @@
// Pipelined CORDIC, one micro-rotation per register stage, rotate or vector mode.
// Depends on ipsd_pkg (step count, widths, arctangent table).
module ipsd_cordic
  import ipsd_pkg::*;
#(
  parameter bit VECTOR = 1'b0,
  parameter int SIDE_W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic signed [ZW-1:0] out_z,
  output logic [SIDE_W-1:0]    out_side
);

  logic                 vld  [CORDIC_STEPS+1];
  logic signed [XW-1:0] xs   [CORDIC_STEPS+1];
  logic signed [XW-1:0] ys   [CORDIC_STEPS+1];
  logic signed [ZW-1:0] zs   [CORDIC_STEPS+1];
  logic [SIDE_W-1:0]    side [CORDIC_STEPS+1];

  assign vld[0]  = in_valid;
  assign xs[0]   = in_x;
  assign ys[0]   = in_y;
  assign zs[0]   = in_z;
  assign side[0] = in_side;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] ang;
    logic                 cw;

    assign dx  = ys[i] >>> i;
    assign dy  = xs[i] >>> i;
    assign ang = atan_turn(i);
    // cw: x -= y>>i, y += x>>i, z -= atan
    assign cw  = VECTOR ? (ys[i] <= 0) : (zs[i] >= 0);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (cw) begin
          xs[i+1] <= xs[i] - dx;
          ys[i+1] <= ys[i] + dy;
          zs[i+1] <= zs[i] - ang;
        end else begin
          xs[i+1] <= xs[i] + dx;
          ys[i+1] <= ys[i] - dy;
          zs[i+1] <= zs[i] + ang;
        end
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign out_x     = xs[CORDIC_STEPS];
  assign out_y     = ys[CORDIC_STEPS];
  assign out_z     = zs[CORDIC_STEPS];
  assign out_side  = side[CORDIC_STEPS];

endmodule

@@ src/ipsd_div.sv @@
// Pipelined saturating restoring divider, one quotient bit per stage.
// Depends on ipsd_pkg (quotient and dividend widths).
module ipsd_div
  import ipsd_pkg::*;
#(
  parameter int SIDE_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DW-1:0]     in_num,
  input  logic [15:0]       in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QB-1:0]     out_q,
  output logic              out_sat,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [QB+1];
  logic [15:0]       rem  [QB+1];
  logic [QB-1:0]     num  [QB+1];
  logic [QB-1:0]     quo  [QB+1];
  logic              sat  [QB+1];
  logic [15:0]       den  [QB+1];
  logic [SIDE_W-1:0] side [QB+1];

  // quotient would not fit in QB bits (also covers a zero divisor)
  assign vld[0]  = in_valid;
  assign sat[0]  = in_num >= {{(DW-QB-16){1'b0}}, in_den, {QB{1'b0}}};
  assign rem[0]  = in_num[QB+15:QB];
  assign num[0]  = in_num[QB-1:0];
  assign quo[0]  = '0;
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar i = 0; i < QB; i++) begin : g_bit
    logic [16:0] trial;
    logic        ge;
    logic [16:0] diff;

    assign trial = {rem[i], num[i][QB-1]};
    assign ge    = trial >= {1'b0, den[i]};
    assign diff  = trial - {1'b0, den[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? diff[15:0] : trial[15:0];
        num[i+1]  <= {num[i][QB-2:0], 1'b0};
        quo[i+1]  <= {quo[i][QB-2:0], ge};
        sat[i+1]  <= sat[i];
        den[i+1]  <= den[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_q     = quo[QB];
  assign out_sat   = sat[QB];
  assign out_side  = side[QB];

endmodule

@@ src/inverse_park_svpwm_duty.sv @@
// Throughput: one item per cycle while the skid register is empty; three 24-stage
//   CORDICs and two 17-stage dividers each take a new item every enabled cycle, and
//   a skid register keeps the input open while one finished result waits.
// Reset (rst, synchronous, active high): clears all valid bits and the skid,
//   pole_pairs returns to 7 and pwm_period to 50000.
module inverse_park_svpwm_duty
  import ipsd_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // command_d, command_q, rotor_angle, bus_voltage
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // duty_a, duty_b, duty_c, sector, zero pad
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "inverse_park_svpwm_duty_defines.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [5:0]  pole_pairs;
  logic [15:0] pwm_period;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pole_pairs <= 6'd7;
      pwm_period <= 16'd50000;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_POLE_PAIRS) begin
        pole_pairs <= pwdata[5:0];
      end else begin
        pwm_period <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_PWM_PERIOD) ? {16'd0, pwm_period} : {26'd0, pole_pairs};

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipe advances while the skid register is empty.
  // ---------------------------------------------------------------------------
  logic adv;
  logic skid_valid;

  assign adv      = ~skid_valid;
  assign s_tready = adv;

  // ---------------------------------------------------------------------------
  // Stage 0: fold the rotor angle into +-quarter turn for the rotation CORDIC
  // ---------------------------------------------------------------------------
  logic                 in_take;
  logic signed [15:0]   cmd_d;
  logic signed [15:0]   cmd_q;
  logic [15:0]          rotor;
  logic [15:0]          vbus_in;
  logic signed [ZW-1:0] t_raw;
  logic signed [XW-1:0] x_in;
  logic signed [XW-1:0] y_in;

  assign in_take = s_tvalid & s_tready;
  assign cmd_d   = s_tdata[15:0];
  assign cmd_q   = s_tdata[31:16];
  assign rotor   = s_tdata[47:32];
  assign vbus_in = s_tdata[63:48];
  // turn * 2^32 read as signed, i.e. -half .. +half
  assign t_raw   = {{2{rotor[15]}}, rotor, 16'd0};
  // volts * 2^20
  assign x_in    = {{4{cmd_d[15]}}, cmd_d, 12'd0};
  assign y_in    = {{4{cmd_q[15]}}, cmd_q, 12'd0};

  logic                 v0;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;
  logic signed [ZW-1:0] z0;
  logic [15:0]          vb0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vb0 <= vbus_in;
      if (t_raw > TURN_QUARTER) begin
        x0 <= -x_in;
        y0 <= -y_in;
        z0 <= t_raw - TURN_HALF;
      end else if (t_raw < -TURN_QUARTER) begin
        x0 <= -x_in;
        y0 <= -y_in;
        z0 <= t_raw + TURN_HALF;
      end else begin
        x0 <= x_in;
        y0 <= y_in;
        z0 <= t_raw;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Inverse Park: rotate (d, q) by the rotor angle
  // ---------------------------------------------------------------------------
  logic                 c1_v;
  logic signed [XW-1:0] c1_x;
  logic signed [XW-1:0] c1_y;
  logic signed [ZW-1:0] c1_z;
  logic [15:0]          c1_vb;

  ipsd_cordic #(.VECTOR(1'b0), .SIDE_W(16)) u_rot_park (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v0),
    .in_x     (x0),
    .in_y     (y0),
    .in_z     (z0),
    .in_side  (vb0),
    .out_valid(c1_v),
    .out_x    (c1_x),
    .out_y    (c1_y),
    .out_z    (c1_z),
    .out_side (c1_vb)
  );

  // Stage 1: remove CORDIC gain -> alpha, beta
  logic signed [63:0]   pa;
  logic signed [63:0]   pb;
  logic                 v1;
  logic signed [XW-1:0] alpha;
  logic signed [XW-1:0] beta;
  logic [15:0]          vb1;
  logic                 c1_z_sign;

  assign pa        = c1_x * KINV_Q30;
  assign pb        = c1_y * KINV_Q30;
  assign c1_z_sign = c1_z[ZW-1]; // residual angle, not needed further

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= c1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      alpha <= pa[61:30];
      beta  <= pb[61:30];
      vb1   <= c1_vb ^ {16{1'b0 & c1_z_sign}};
    end
  end

  // Stage 2: move the vector into the right half plane for vectoring
  logic                 v2;
  logic signed [XW-1:0] x2;
  logic signed [XW-1:0] y2;
  logic signed [ZW-1:0] z2;
  logic [15:0]          vb2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vb2 <= vb1;
      if (alpha < 0) begin
        x2 <= -alpha;
        y2 <= -beta;
        z2 <= TURN_HALF;
      end else begin
        x2 <= alpha;
        y2 <= beta;
        z2 <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Vectoring CORDIC: magnitude and atan2 angle of (alpha, beta)
  // ---------------------------------------------------------------------------
  logic                 c2_v;
  logic signed [XW-1:0] c2_x;
  logic signed [XW-1:0] c2_y;
  logic signed [ZW-1:0] c2_z;
  logic [15:0]          c2_vb;

  ipsd_cordic #(.VECTOR(1'b1), .SIDE_W(16)) u_vec (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v2),
    .in_x     (x2),
    .in_y     (y2),
    .in_z     (z2),
    .in_side  (vb2),
    .out_valid(c2_v),
    .out_x    (c2_x),
    .out_y    (c2_y),
    .out_z    (c2_z),
    .out_side (c2_vb)
  );

  // Stage 3: gain removal, tiny magnitudes forced to zero with angle zero
  logic signed [63:0]   pm;
  logic signed [XW-1:0] mag_raw;
  logic                 mag_small;
  logic                 v3;
  logic [31:0]          mag3;
  logic [31:0]          zu3;
  logic [15:0]          vb3;
  logic                 c2_y_sign;

  assign pm        = c2_x * KINV_Q30;
  assign mag_raw   = pm[61:30];
  assign mag_small = mag_raw < MAG_MIN_Q20;
  assign c2_y_sign = c2_y[XW-1]; // residual y, not needed further

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vb3  <= c2_vb ^ {16{1'b0 & c2_y_sign}};
      mag3 <= mag_small ? 32'd0 : mag_raw;
      zu3  <= mag_small ? 32'd0 : c2_z[31:0];
    end
  end

  // Stage 4: electrical angle = vector angle * pole_pairs, wrapped
  logic [ANGLE_BITS+5:0] elec_prod;
  logic                  v4;
  logic [ANGLE_BITS-1:0] elec;
  logic [31:0]           mag4;
  logic [15:0]           vb4;

  assign elec_prod = zu3[31 -: ANGLE_BITS] * pole_pairs;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      elec <= elec_prod[ANGLE_BITS-1:0];
      mag4 <= mag3;
      vb4  <= vb3;
    end
  end

  // Stage 5: sector = floor(6 * angle), angle behind the sector start
  logic [ANGLE_BITS+2:0] elec6;
  logic [2:0]            sec5_n;
  logic [31:0]           th;
  logic                  v5;
  logic [31:0]           behind;
  ipsd_side_t            side5;

  assign elec6  = ({3'd0, elec} << 2) + ({3'd0, elec} << 1);
  assign sec5_n = elec6[ANGLE_BITS+2:ANGLE_BITS];
  assign th     = {elec, {(32-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      behind       <= th - sect_base(sec5_n);
      side5.vbus   <= vb4;
      side5.mag    <= mag4;
      side5.sector <= sec5_n;
    end
  end

  // ---------------------------------------------------------------------------
  // Sine/cosine of the in-sector angle (gain pre-compensated start vector)
  // ---------------------------------------------------------------------------
  logic                 c3_v;
  logic signed [XW-1:0] c3_x;
  logic signed [XW-1:0] c3_y;
  logic signed [ZW-1:0] c3_z;
  ipsd_side_t           c3_side;

  ipsd_cordic #(.VECTOR(1'b0), .SIDE_W($bits(ipsd_side_t))) u_rot_sin (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v5),
    .in_x     (KINV_Q30),
    .in_y     ('0),
    .in_z     ({2'b00, behind}),
    .in_side  (side5),
    .out_valid(c3_v),
    .out_x    (c3_x),
    .out_y    (c3_y),
    .out_z    (c3_z),
    .out_side (c3_side)
  );

  // Stage 6: s_fwd = sin(60 - t) = cos*sqrt3/2 - sin/2, s_back = sin t, both >= 0
  logic signed [63:0]   ph;
  logic signed [XW-1:0] sf_raw;
  logic                 v6;
  logic [30:0]          sf6;
  logic [30:0]          sb6;
  ipsd_side_t           side6;
  logic                 c3_z_sign;

  assign ph        = c3_x * HALF_SQRT3_Q30;
  assign sf_raw    = ph[61:30] - (c3_y >>> 1);
  assign c3_z_sign = c3_z[ZW-1]; // residual angle, not needed further

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= c3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sf6   <= (sf_raw < 0) ? 31'd0 : sf_raw[30:0];
      sb6   <= (c3_y < 0) ? 31'd0 : c3_y[30:0];
      side6 <= c3_side;
      if (c3_z_sign & 1'b0) begin
        side6.sector <= '0;
      end
    end
  end

  // Stage 7: a = U * s >> 30
  logic [62:0] paf;
  logic [62:0] pab;
  logic        v7;
  logic [31:0] af7;
  logic [31:0] ab7;
  logic [15:0] vb7;
  logic [2:0]  sec7;

  assign paf = side6.mag * sf6;
  assign pab = side6.mag * sb6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      af7  <= paf[61:30];
      ab7  <= pab[61:30];
      vb7  <= side6.vbus;
      sec7 <= side6.sector;
    end
  end

  // Stage 8: scale by sqrt(3)
  logic [48:0] n1f;
  logic [48:0] n1b;
  logic        v8;
  logic [48:0] nf8;
  logic [48:0] nb8;
  logic [15:0] vb8;
  logic [2:0]  sec8;

  assign n1f = af7 * SQRT3_Q16;
  assign n1b = ab7 * SQRT3_Q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nf8  <= n1f;
      nb8  <= n1b;
      vb8  <= vb7;
      sec8 <= sec7;
    end
  end

  // Stage 9: scale by the period, drop the 2^28 of the divisor
  logic [64:0]   n2f;
  logic [64:0]   n2b;
  logic          v9;
  logic [DW-1:0] df9;
  logic [DW-1:0] db9;
  logic [15:0]   vb9;
  logic [2:0]    sec9;

  assign n2f = nf8 * pwm_period;
  assign n2b = nb8 * pwm_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      df9  <= n2f[64:28];
      db9  <= n2b[64:28];
      vb9  <= vb8;
      sec9 <= sec8;
    end
  end

  // ---------------------------------------------------------------------------
  // Active times: divide by the bus voltage
  // ---------------------------------------------------------------------------
  logic          dvf_v;
  logic [QB-1:0] qf;
  logic          satf;
  logic [2:0]    dv_sec;
  logic          dvb_v;
  logic [QB-1:0] qb;
  logic          satb;
  logic [2:0]    dvb_side;

  ipsd_div #(.SIDE_W(3)) u_div_fwd (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v9),
    .in_num   (df9),
    .in_den   (vb9),
    .in_side  (sec9),
    .out_valid(dvf_v),
    .out_q    (qf),
    .out_sat  (satf),
    .out_side (dv_sec)
  );

  ipsd_div #(.SIDE_W(3)) u_div_back (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v9),
    .in_num   (db9),
    .in_den   (vb9),
    .in_side  (sec9),
    .out_valid(dvb_v),
    .out_q    (qb),
    .out_sat  (satb),
    .out_side (dvb_side)
  );

  // Stage 10: clamp both times to the period
  logic        v10;
  logic [15:0] tf;
  logic [15:0] tb;
  logic [2:0]  sec10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (adv) begin
      v10 <= dvf_v & dvb_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tf    <= (satf || qf > {1'b0, pwm_period}) ? pwm_period : qf[15:0];
      tb    <= (satb || qb > {1'b0, pwm_period}) ? pwm_period : qb[15:0];
      sec10 <= dv_sec | (dvb_side & 3'b000);
    end
  end

  // ---------------------------------------------------------------------------
  // Seven-segment duties: half the zero time on each side, phase order per sector
  // ---------------------------------------------------------------------------
  logic [16:0] sum;
  logic [16:0] per17;
  logic [16:0] t0;
  logic [16:0] da17;
  logic [16:0] db17;
  logic [16:0] dc17;
  logic [15:0] duty_a;
  logic [15:0] duty_b;
  logic [15:0] duty_c;
  logic [55:0] result;

  assign per17 = {1'b0, pwm_period};
  assign sum   = {1'b0, tf} + {1'b0, tb};
  assign t0    = (sum >= per17) ? 17'd0 : ((per17 - sum) >> 1);

  always_comb begin
    unique case (sec10)
      SEC_0: begin
        da17 = sum + t0;
        db17 = {1'b0, tb} + t0;
        dc17 = t0;
      end
      SEC_1: begin
        da17 = {1'b0, tf} + t0;
        db17 = sum + t0;
        dc17 = t0;
      end
      SEC_2: begin
        da17 = t0;
        db17 = sum + t0;
        dc17 = {1'b0, tb} + t0;
      end
      SEC_3: begin
        da17 = t0;
        db17 = {1'b0, tf} + t0;
        dc17 = sum + t0;
      end
      SEC_4: begin
        da17 = {1'b0, tb} + t0;
        db17 = t0;
        dc17 = sum + t0;
      end
      default: begin
        da17 = sum + t0;
        db17 = t0;
        dc17 = {1'b0, tf} + t0;
      end
    endcase
  end

  assign duty_a = (da17 > per17) ? pwm_period : da17[15:0];
  assign duty_b = (db17 > per17) ? pwm_period : db17[15:0];
  assign duty_c = (dc17 > per17) ? pwm_period : dc17[15:0];
  assign result = {5'd0, sec10, duty_c, duty_b, duty_a};

  // ---------------------------------------------------------------------------
  // Output register plus skid register
  // ---------------------------------------------------------------------------
  logic        out_take;
  logic [55:0] skid;

  assign out_take = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (v10) begin
      if (!m_tvalid || out_take) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        m_tdata <= skid;
      end
    end else if (v10) begin
      if (!m_tvalid || out_take) begin
        m_tdata <= result;
      end else begin
        skid <= result;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `IPSD_ASSERT(a_skid_behind_out, clk, rst, skid_valid |-> m_tvalid)
  `IPSD_ASSERT(a_sector_range, clk, rst, m_tvalid |-> (m_tdata[50:48] <= 3'd5))
  `IPSD_ASSERT(a_duty_range, clk, rst, m_tvalid |-> (m_tdata[15:0] <= pwm_period && m_tdata[31:16] <= pwm_period && m_tdata[47:32] <= pwm_period))
  `IPSD_ASSERT_NEXT(a_skid_holds, clk, rst, skid_valid && !m_tready, skid_valid)

endmodule

@@ verif/tb_top.sv @@
// Testbench for inverse_park_svpwm_duty: d/q commands and rotor angle in, three phase
// duties and the sector out. Results are checked against a bit-exact model of the
// fixed-point datapath. Depends on ipsd_pkg and the block's RTL.
module tb_top;
  import ipsd_pkg::*;

  localparam int LATENCY = 101;
  localparam longint CYCLE_LIMIT = 400000;

  // result fields as they leave the block
  typedef struct {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector;
  } duty_set_t;

  // floor shift of a signed value
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    return longint'(atan_turn(i));
  endfunction

  // Rotation mode: turn (x, y) by z. The result still carries the CORDIC gain.
  task automatic cordic_turn(inout longint x, inout longint y, input longint z);
    longint dx, dy;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
  endtask

  // Vectoring mode: drive y to zero and collect the angle in z.
  task automatic cordic_aim(inout longint x, inout longint y, inout longint z);
    longint dx, dy;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
  endtask

  function automatic longint unsigned on_time(longint unsigned mag, longint unsigned s,
                                              longint unsigned per, longint unsigned vb);
    longint unsigned a, t;
    if (vb == 0) return per;
    a = (mag * s) >> 30;
    t = (a * longint'(SQRT3_Q16) * per) / (vb << 28);
    return (t > per) ? per : t;
  endfunction

  // Works out the duties and sector of one command under the given settings.
  task automatic svpwm_duties(input logic [63:0] cmd, input logic [5:0] pp,
                              input logic [15:0] period, output duty_set_t r);
    longint x, y, t, z, alpha, beta, cx, sy, sf, sb;
    longint unsigned per, vb, mag, zu, elec, th, sec, behind, tf, tb, sum, t0;
    longint unsigned da, db, dc;
    per = period;
    vb = cmd[63:48];
    x = longint'($signed(cmd[15:0])) * 4096;
    y = longint'($signed(cmd[31:16])) * 4096;
    t = longint'(cmd[47:32]) << 16;
    if (t >= 64'sd2147483648) t -= 64'sd4294967296;
    if (t > 64'sd1073741824) begin
      x = -x; y = -y; t -= 64'sd2147483648;
    end else if (t < -64'sd1073741824) begin
      x = -x; y = -y; t += 64'sd2147483648;
    end
    cordic_turn(x, y, t);
    alpha = fshr(x * longint'(KINV_Q30), 30);
    beta = fshr(y * longint'(KINV_Q30), 30);
    if (alpha < 0) begin
      x = -alpha; y = -beta; z = 64'sd2147483648;
    end else begin
      x = alpha; y = beta; z = 0;
    end
    cordic_aim(x, y, z);
    mag = longint'(fshr(x * longint'(KINV_Q30), 30));
    if (mag < 1049) begin
      mag = 0; z = 0;
    end
    zu = z & 64'hFFFF_FFFF;
    elec = ((zu >> 16) * pp) & 64'hFFFF;
    th = (elec << 16) & 64'hFFFF_FFFF;
    sec = (th * 6) >> 32;
    behind = th - ((sec << 32) + 5) / 6;
    cx = longint'(KINV_Q30);
    sy = 0;
    cordic_turn(cx, sy, longint'(behind));
    sb = (sy < 0) ? 0 : sy;
    sf = fshr(cx * longint'(HALF_SQRT3_Q30), 30) - fshr(sy, 1);
    if (sf < 0) sf = 0;
    tf = on_time(mag, sf, per, vb);
    tb = on_time(mag, sb, per, vb);
    sum = tf + tb;
    t0 = (sum >= per) ? 0 : (per - sum) / 2;
    case (ipsd_sector_t'(sec[2:0]))
      SEC_0: begin da = sum + t0; db = tb + t0;  dc = t0;       end
      SEC_1: begin da = tf + t0;  db = sum + t0; dc = t0;       end
      SEC_2: begin da = t0;       db = sum + t0; dc = tb + t0;  end
      SEC_3: begin da = t0;       db = tf + t0;  dc = sum + t0; end
      SEC_4: begin da = tb + t0;  db = t0;       dc = sum + t0; end
      default: begin da = sum + t0; db = t0;     dc = tf + t0;  end
    endcase
    r.duty_a = (da > per) ? per[15:0] : da[15:0];
    r.duty_b = (db > per) ? per[15:0] : db[15:0];
    r.duty_c = (dc > per) ? per[15:0] : dc[15:0];
    r.sector = sec[2:0];
  endtask

  int mismatches = 0;

  task automatic report(string what, longint got, longint want);
    mismatches++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // Holds the expected duty sets in order and checks each result against the oldest.
  class duty_board;
    duty_set_t pending[$];
    logic [5:0] pole_pairs = 6'd7;
    logic [15:0] period = 16'd50000;
    int checked = 0;

    task note_command(logic [63:0] cmd);
      duty_set_t r;
      svpwm_duties(cmd, pole_pairs, period, r);
      pending.push_back(r);
    endtask

    task check_result(logic [55:0] d);
      duty_set_t w;
      if (pending.size() == 0) begin
        report("unexpected result", d[15:0], -1);
        return;
      end
      w = pending.pop_front();
      checked++;
      if (d[15:0] !== w.duty_a) report("duty_a", d[15:0], w.duty_a);
      if (d[31:16] !== w.duty_b) report("duty_b", d[31:16], w.duty_b);
      if (d[47:32] !== w.duty_c) report("duty_c", d[47:32], w.duty_c);
      if (d[50:48] !== w.sector) report("sector", d[50:48], w.sector);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [55:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  inverse_park_svpwm_duty dut (.*);

  always #5 clk = ~clk;

  duty_board board = new();
  bit quiet = 0;       // no idling on either side
  bit hold_off = 0;    // long receiver stall requested
  longint cycles = 0;

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // input side bookkeeping: note every accepted transfer
  always @(posedge clk)
    if (!rst && s_tvalid && s_tready) board.note_command(s_tdata);

  // result side: check accepted transfers
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);

  // receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        m_tready <= 0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        n = $urandom_range(1, 17);
        repeat (n) @(negedge clk);
      end else begin
        m_tready <= 1;
        @(negedge clk);
      end
    end
  end

  task automatic reg_write(ipsd_reg_t idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'(idx) << 2; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_POLE_PAIRS) board.pole_pairs = v[5:0];
    else board.period = v[15:0];
  endtask

  // sends one command, with a random gap before it unless quiet
  task automatic send(logic [63:0] cmd);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 0;
      n = $urandom_range(1, 17);
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [63:0] pack(logic [15:0] d, logic [15:0] q, logic [15:0] ang,
                                       logic [15:0] vb);
    return {vb, ang, q, d};
  endfunction

  // random command: mostly normal voltages, sometimes tiny or full-scale
  function automatic logic [63:0] rand_cmd();
    logic [15:0] d, q, vb;
    case ($urandom_range(0, 5))
      0: begin
        d = 16'($urandom_range(0, 3) - 1);
        q = 16'($urandom_range(0, 3) - 1);
      end
      1: begin d = 16'($urandom); q = 16'($urandom); end
      default: begin
        d = 16'($signed($urandom_range(0, 6000)) - 3000);
        q = 16'($signed($urandom_range(0, 6000)) - 3000);
      end
    endcase
    vb = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                     : 16'($urandom_range(2000, 12000));
    return pack(d, q, 16'($urandom), vb);
  endfunction

  // drain outstanding results, then let the pipe settle
  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  initial begin
    logic [15:0] ext[6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0100, 16'hFF00};
    logic [5:0] pps[5] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd4};
    logic [15:0] pers[5] = '{16'd65535, 16'd1, 16'd0, 16'd1000, 16'd20000};
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: extremes, tiny vectors, angles at sector edges, bus extremes
    for (int i = 0; i < 6; i++)
      send(pack(ext[i], ext[5 - i], 16'(i * 10923), (i % 2) ? 16'hFFFF : 16'h0001));
    send(pack(16'h0000, 16'h0000, 16'h1234, 16'h0C00));
    send(pack(16'h0001, 16'h0000, 16'h0000, 16'h0C00));
    send(pack(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0C00));
    for (int i = 0; i < 6; i++)
      send(pack(16'h0200, 16'h0000, 16'(i * 65536 / 42), 16'h0C00));
    send(pack(16'h7FFF, 16'h7FFF, 16'h4000, 16'h0001));
    send(pack(16'h0800, 16'h0800, 16'hC000, 16'h0800));
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      reg_write(REG_POLE_PAIRS, {26'($urandom), pps[ph]});
      reg_write(REG_PWM_PERIOD, {16'($urandom), pers[ph]});
      if (ph == 2) begin
        hold_off = 1;
        @(negedge clk);
      end
      if (ph == 4) quiet = 1;
      for (int i = 0; i < 240; i++) send(rand_cmd());
      drain();
    end

    $display("covered %0d checked results over five pole-pair/period settings",
             board.checked);
    $display("including zero period, zero pole pairs, overmodulation and a long stall");
    if (mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
